>>> rtl/psrm_pkg.sv
// Shared constants and types for the priority subsequence rule matcher.
package psrm_pkg;

  // Default sizes
  localparam int DEF_RULE_COUNT      = 4;
  localparam int DEF_MAX_RULE_LENGTH = 8;
  localparam int DEF_TOKEN_BITS      = 4;

  // Rule word layout: token slots from bit 0, length, good flag
  localparam int CFG_WORD_W = 37;
  localparam int LEN_LSB    = 32;
  localparam int LEN_W      = 4;
  localparam int GOOD_BIT   = 36;

  // Progress counter holds 0..MAX_RULE_LENGTH (at most 8)
  localparam int PROG_W = 4;

  // Configuration port: one register per rule for the first CFG_REGS rules
  localparam int CFG_REGS  = 4;
  localparam int CFG_IDX_W = 2;

  // Verdict codes
  localparam logic signed [1:0] VERDICT_NONE = 2'sb00;
  localparam logic signed [1:0] VERDICT_GOOD = 2'sb01;
  localparam logic signed [1:0] VERDICT_BAD  = 2'sb11;

  // Verdict travelling down the cell chain
  typedef struct packed {
    logic hit;
    logic good;
  } verdict_t;

endpackage

>>> rtl/psrm_cell.sv
// One rule cell: rule word, progress counter and one link of the priority chain.
module psrm_cell
  import psrm_pkg::*;
#(
  parameter int MAX_RULE_LENGTH = DEF_MAX_RULE_LENGTH,
  parameter int TOKEN_BITS      = DEF_TOKEN_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_WORD_W-1:0] cfg_data,
  input  logic                  tok_take,
  input  logic [TOKEN_BITS-1:0] tok,
  input  logic                  tok_last,
  input  verdict_t              chain_in,
  output verdict_t              chain_out
);

  localparam int SLOT_SPAN = MAX_RULE_LENGTH * TOKEN_BITS;
  localparam int WIDE_W    = CFG_WORD_W + SLOT_SPAN;

  logic [CFG_WORD_W-1:0] word_r;
  logic [PROG_W-1:0]     prog_r, prog_nxt;
  logic [LEN_W-1:0]      len_raw;
  logic [PROG_W-1:0]     len;
  logic [WIDE_W-1:0]     wide;
  logic [TOKEN_BITS-1:0] exp_tok;
  logic                  adv;
  logic [PROG_W-1:0]     prog_upd;
  logic                  done;

  // Rule length, saturated to the maximum
  assign len_raw = word_r[LEN_LSB +: LEN_W];
  assign len = (PROG_W'(len_raw) > PROG_W'(MAX_RULE_LENGTH)) ?
               PROG_W'(MAX_RULE_LENGTH) : PROG_W'(len_raw);

  // Expected token at the current progress; slots past the word read as upper bits/zero
  assign wide = {{SLOT_SPAN{1'b0}}, word_r};
  always_comb begin
    exp_tok = '0;
    for (int s = 0; s < MAX_RULE_LENGTH; s++) begin
      if (prog_r == PROG_W'(s)) begin
        exp_tok = wide[s*TOKEN_BITS +: TOKEN_BITS];
      end
    end
  end

  // Advance on a match while not complete
  assign adv      = (prog_r < len) && (exp_tok == tok);
  assign prog_upd = adv ? prog_r + PROG_W'(1) : prog_r;
  assign done     = (len != '0) && (prog_upd >= len);

  // Lower-numbered cell overrides anything from above
  always_comb begin
    if (done) begin
      chain_out.hit  = 1'b1;
      chain_out.good = word_r[GOOD_BIT];
    end else begin
      chain_out = chain_in;
    end
  end

  // Progress clears after the last token of a path
  always_comb begin
    prog_nxt = prog_r;
    if (tok_take) begin
      prog_nxt = tok_last ? '0 : prog_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
      prog_r <= '0;
    end else begin
      prog_r <= prog_nxt;
      if (cfg_we) begin
        word_r <= cfg_data;
      end
    end
  end

endmodule

>>> rtl/psrm_out_buf.sv
// Two-word output buffer: output register plus skid register.
module psrm_out_buf
  import psrm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic signed [1:0] push_verdict,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [1:0] out_verdict
);

  logic              head_valid_r, head_valid_nxt;
  logic signed [1:0] head_verdict_r, head_verdict_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic signed [1:0] skid_verdict_r, skid_verdict_nxt;
  logic              pop;

  assign pop = head_valid_r && !out_stall;

  // Head refills from skid first, then from the new word
  always_comb begin
    head_valid_nxt   = head_valid_r;
    head_verdict_nxt = head_verdict_r;
    skid_valid_nxt   = skid_valid_r;
    skid_verdict_nxt = skid_verdict_r;
    if (pop || !head_valid_r) begin
      if (skid_valid_r) begin
        head_valid_nxt   = 1'b1;
        head_verdict_nxt = skid_verdict_r;
        skid_valid_nxt   = push;
        skid_verdict_nxt = push_verdict;
      end else begin
        head_valid_nxt   = push;
        head_verdict_nxt = push_verdict;
      end
    end else if (push) begin
      skid_valid_nxt   = 1'b1;
      skid_verdict_nxt = push_verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_verdict_r <= head_verdict_nxt;
    skid_verdict_r <= skid_verdict_nxt;
  end

  assign full        = skid_valid_r;
  assign out_valid   = head_valid_r;
  assign out_verdict = head_verdict_r;

endmodule

>>> rtl/priority_subsequence_rule_matcher.sv
// Top level of the priority subsequence rule matcher: cell chain and output buffer.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_token, in_path_end
//   out      output     out_valid/out_stall  out_verdict
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One token is taken every cycle while in_stall is low; all rule cells compare
// and count in parallel; a path_end token's verdict is registered in the buffer.
// The two-word output buffer keeps tokens flowing while out_stall is high,
// and in_stall rises only once both buffer words are full.
// Synchronous active-low reset clears rules, progress and the buffer.
module priority_subsequence_rule_matcher
  import psrm_pkg::*;
#(
  parameter int RULE_COUNT      = DEF_RULE_COUNT,
  parameter int MAX_RULE_LENGTH = DEF_MAX_RULE_LENGTH,
  parameter int TOKEN_BITS      = DEF_TOKEN_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TOKEN_BITS-1:0] in_token,
  input  logic                  in_path_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [1:0]     out_verdict,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_WORD_W-1:0] cfg_data
);

  logic              in_take;
  logic              cfg_take;
  logic              buf_full;
  logic signed [1:0] verdict;
  verdict_t          chain [RULE_COUNT+1];

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign in_take   = in_valid && !in_stall;
  assign in_stall  = buf_full;

  // Nothing above the highest rule
  assign chain[RULE_COUNT] = '0;

  // Rule cells; only the first CFG_REGS have a write enable
  for (genvar r = 0; r < RULE_COUNT; r++) begin : g_cell
    logic we;
    if (r < CFG_REGS) begin : g_we
      assign we = cfg_take && (cfg_index == CFG_IDX_W'(r));
    end else begin : g_no_we
      assign we = 1'b0;
    end

    psrm_cell #(
      .MAX_RULE_LENGTH (MAX_RULE_LENGTH),
      .TOKEN_BITS      (TOKEN_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg_we    (we),
      .cfg_data  (cfg_data),
      .tok_take  (in_take),
      .tok       (in_token),
      .tok_last  (in_path_end),
      .chain_in  (chain[r+1]),
      .chain_out (chain[r])
    );
  end

  // Verdict from the lowest-numbered completed rule
  always_comb begin
    if (!chain[0].hit) begin
      verdict = VERDICT_NONE;
    end else if (chain[0].good) begin
      verdict = VERDICT_GOOD;
    end else begin
      verdict = VERDICT_BAD;
    end
  end

  psrm_out_buf u_out_buf (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (in_take && in_path_end),
    .push_verdict (verdict),
    .full         (buf_full),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_verdict  (out_verdict)
  );

endmodule
